/* design/utf8_stream_decoder_defines.svh */
// Assertion macros shared by the UTF-8 stream decoder checker.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define UTF8SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8sd check failed");

// Next-cycle implication, disabled while reset is held.
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8sd check failed");

`endif

/* design/utf8sd_pkg.sv */
// Types, constants and lead byte decoding for the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;
    localparam int REM_W   = 3;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REP_CP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_EN = 1'd1;

    localparam logic [CP_W-1:0] REP_CP_RESET = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_NONCHAR_E = 21'h00FFFE;
    localparam logic [CP_W-1:0] CP_NONCHAR_F = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

    typedef struct packed {
        logic [CP_W-1:0]  acc;
        logic [REM_W-1:0] rem;
        logic             inv;
    } t_lead;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_code_point;
        logic            replaced;
        logic            end_of_buffer;
        logic            stopped_early;
    } t_result;

    // Payload bits and remaining length of a sequence from its lead byte.
    function automatic t_lead lead_decode(input logic [BYTE_W-1:0] b);
        t_lead l;
        l.inv = 1'b0;
        if (b[7] == 1'b0) begin
            l.acc = {13'd0, b};
            l.rem = 3'd0;
        end else if ((b & 8'hE0) == 8'hC0) begin
            l.acc = {16'd0, b[4:0]};
            l.rem = 3'd1;
        end else if ((b & 8'hF0) == 8'hE0) begin
            l.acc = {17'd0, b[3:0]};
            l.rem = 3'd2;
        end else if ((b & 8'hF8) == 8'hF0) begin
            l.acc = {18'd0, b[2:0]};
            l.rem = 3'd3;
        end else if ((b & 8'hFC) == 8'hF8) begin
            l.acc = {19'd0, b[1:0]};
            l.rem = 3'd4;
            l.inv = 1'b1;
        end else if ((b & 8'hFE) == 8'hFC) begin
            l.acc = {20'd0, b[0]};
            l.rem = 3'd5;
            l.inv = 1'b1;
        end else begin
            l.acc = {13'd0, b};
            l.rem = 3'd0;
            l.inv = 1'b1;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

/* design/utf8sd_byte_if.sv */
// Byte input channel of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

interface utf8sd_byte_if import utf8sd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_in_buffer;

    modport source (output valid, output data_byte, output last_in_buffer, input ready);
    modport sink   (input valid, input data_byte, input last_in_buffer, output ready);
endinterface

`default_nettype wire

/* design/utf8sd_cp_if.sv */
// Code point result channel of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

interface utf8sd_cp_if import utf8sd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            has_code_point;
    logic            replaced;
    logic            end_of_buffer;
    logic            stopped_early;

    modport source (output valid, output code_point, output has_code_point,
                    output replaced, output end_of_buffer, output stopped_early,
                    input ready);
    modport sink   (input valid, input code_point, input has_code_point,
                    input replaced, input end_of_buffer, input stopped_early,
                    output ready);
endinterface

`default_nettype wire

/* design/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: one byte in, at most one code point out.
//
// Bytes arrive on i_byte, one per transaction, with last_in_buffer marking the
// final byte of a buffer. Results leave on o_cp; a byte gives either no result
// or exactly one, and the last byte of a buffer always gives one, carrying
// end_of_buffer and, where decoding halted or the final sequence was cut off,
// stopped_early.
// The result of an accepted byte is registered and is on o_cp from the next
// cycle. Throughput is one byte per cycle while the receiver keeps up; the
// decode of a byte is a single pass of lead decode, six-bit shift and range
// compare between the sequence state registers and the result register.
// The result register parts the two sides: a new byte is taken whenever the
// register is empty or its transaction completes in the same cycle. If the
// receiver stalls, the result is held and i_byte.ready drops until it is taken.
// Synchronous reset clears the sequence state and the result valid flag, and
// sets the replacement code point to U+FFFD with replacement enabled. The
// configuration port writes those two registers at a non-reset edge with i_cfg_we.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder import utf8sd_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CP_W-1:0]       i_cfg_data,
    utf8sd_byte_if.sink          i_byte,
    utf8sd_cp_if.source          o_cp
);

    // Sequence state.
    logic [CP_W-1:0]  r_acc, n_acc;
    logic [REM_W-1:0] r_rem, n_rem;
    logic             r_inv, n_inv;
    logic             r_brk, n_brk;
    logic             r_halt, n_halt;

    // Configuration registers.
    logic [CP_W-1:0]  r_rep_cp;
    logic             r_rep_en;

    // Result register.
    logic             r_out_valid;
    t_result          r_out, n_out;
    logic             n_out_valid;

    // Intermediate values of the decode of the current byte.
    logic [CP_W-1:0]  s_acc;
    logic [REM_W-1:0] s_rem;
    logic             s_inv, s_brk, s_halt;
    logic             emit, rep, err;
    logic [CP_W-1:0]  cp;
    t_lead            lead;
    logic             accept;

    assign i_byte.ready = !r_out_valid || o_cp.ready;
    assign accept       = i_byte.valid && i_byte.ready;

    assign lead = lead_decode(i_byte.data_byte);

    always_comb begin
        s_acc  = r_acc;
        s_rem  = r_rem;
        s_inv  = r_inv;
        s_brk  = r_brk;
        s_halt = r_halt;
        emit   = 1'b0;
        rep    = 1'b0;
        err    = 1'b0;
        cp     = '0;
        if (!r_halt) begin
            if (r_rem == '0) begin
                s_acc = lead.acc;
                s_rem = lead.rem;
                s_inv = lead.inv;
                s_brk = 1'b0;
            end else begin
                // A broken continuation freezes the partial value, but the
                // remaining bytes of the sequence are still counted off.
                if (!r_brk) begin
                    if ((i_byte.data_byte & CONT_MASK) != CONT_TAG) begin
                        s_brk = 1'b1;
                    end else begin
                        s_acc = {r_acc[CP_W-7:0], i_byte.data_byte[5:0]};
                    end
                end
                s_rem = r_rem - 3'd1;
            end
            if (s_rem == '0) begin
                err = s_inv || (s_acc == CP_NONCHAR_E) || (s_acc == CP_NONCHAR_F)
                      || (s_acc > CP_MAX);
                if (err) begin
                    if (r_rep_en) begin
                        emit = 1'b1;
                        rep  = 1'b1;
                        cp   = r_rep_cp;
                    end
                end else begin
                    emit = 1'b1;
                    cp   = s_acc;
                end
                s_halt = s_brk;
                s_acc  = '0;
                s_inv  = 1'b0;
                s_brk  = 1'b0;
            end
        end

        n_out.code_point     = cp;
        n_out.has_code_point = emit;
        n_out.replaced       = rep;
        n_out.end_of_buffer  = i_byte.last_in_buffer;
        n_out.stopped_early  = i_byte.last_in_buffer && (s_halt || (s_rem != '0));
        n_out_valid          = emit || i_byte.last_in_buffer;

        // The end of a buffer returns the sequence state to its reset values.
        if (i_byte.last_in_buffer) begin
            n_acc  = '0;
            n_rem  = '0;
            n_inv  = 1'b0;
            n_brk  = 1'b0;
            n_halt = 1'b0;
        end else begin
            n_acc  = s_acc;
            n_rem  = s_rem;
            n_inv  = s_inv;
            n_brk  = s_brk;
            n_halt = s_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_rem       <= '0;
            r_inv       <= 1'b0;
            r_brk       <= 1'b0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rep_cp    <= REP_CP_RESET;
            r_rep_en    <= 1'b1;
        end else begin
            if (accept) begin
                r_acc       <= n_acc;
                r_rem       <= n_rem;
                r_inv       <= n_inv;
                r_brk       <= n_brk;
                r_halt      <= n_halt;
                r_out_valid <= n_out_valid;
            end else if (o_cp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REP_CP: begin
                        r_rep_cp <= i_cfg_data;
                    end
                    CFG_REP_EN: begin
                        r_rep_en <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // The result payload only changes when a new result is loaded.
    always_ff @(posedge i_clk) begin
        if (accept && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_cp.valid          = r_out_valid;
    assign o_cp.code_point     = r_out.code_point;
    assign o_cp.has_code_point = r_out.has_code_point;
    assign o_cp.replaced       = r_out.replaced;
    assign o_cp.end_of_buffer  = r_out.end_of_buffer;
    assign o_cp.stopped_early  = r_out.stopped_early;

endmodule

`default_nettype wire

/* design/utf8sd_checker.sv */
// Port-level assertion checker for the UTF-8 stream decoder, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_defines.svh"

module utf8sd_checker import utf8sd_pkg::*; (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            i_in_ready,
    input wire            i_in_last,
    input wire            i_out_valid,
    input wire            i_out_ready,
    input wire [CP_W-1:0] i_out_cp,
    input wire            i_out_has,
    input wire            i_out_rep,
    input wire            i_out_eob,
    input wire            i_out_stop
);

    // The last byte of a buffer always closes it on the following cycle.
    `UTF8SD_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, i_out_valid && i_out_eob)
    // Only the closing result may come without a code point.
    `UTF8SD_ASSERT_NOW(a_empty_only_eob, i_clk, i_rst_n, i_out_valid && !i_out_has, i_out_eob)
    // A replacement always carries a code point.
    `UTF8SD_ASSERT_NOW(a_rep_has_cp, i_clk, i_rst_n, i_out_valid && i_out_rep, i_out_has)
    // An early stop is reported only on the closing result.
    `UTF8SD_ASSERT_NOW(a_stop_only_eob, i_clk, i_rst_n, i_out_valid && i_out_stop, i_out_eob)
    // A stalled result holds its code point.
    `UTF8SD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_cp))

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_in_last   (i_byte.last_in_buffer),
    .i_out_valid (o_cp.valid),
    .i_out_ready (o_cp.ready),
    .i_out_cp    (o_cp.code_point),
    .i_out_has   (o_cp.has_code_point),
    .i_out_rep   (o_cp.replaced),
    .i_out_eob   (o_cp.end_of_buffer),
    .i_out_stop  (o_cp.stopped_early)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the UTF-8 stream decoder, with its own behavioural decoder.
`timescale 1ns / 1ps

module tb;
    import utf8sd_pkg::*;

    // The run is cut off here if the stream stalls, with a wide margin over
    // the slowest correct run.
    localparam int unsigned RUN_LIMIT   = 200000;
    localparam int          N_PHASES    = 6;
    localparam int          PHASE_ITEMS = 254;
    localparam int          SETTLE_CYC  = 8;

    // Results that the directed table spells out by hand. The field order is
    // code point, then has_code_point, replaced, end_of_buffer and stopped_early.
    localparam t_result NO_RES      = '0;
    localparam t_result RES_NUL     = {21'h0, 4'b1000};
    localparam t_result RES_REP     = {REP_CP_RESET, 4'b1100};
    localparam t_result RES_REP_END = {REP_CP_RESET, 4'b1110};
    localparam t_result RES_CUT_END = {21'h0, 4'b0011};

    typedef struct packed {
        logic [CP_W-1:0]  acc;
        logic [REM_W-1:0] left;
        logic             bad_lead;
        logic             cont_broken;
        logic             halted;
    } t_seq_state;

    typedef struct {
        logic [BYTE_W-1:0] data_byte;
        logic              last_in_buffer;
        bit                typed;
        t_result           want;
    } t_stim_row;

    typedef struct {
        logic [BYTE_W-1:0] data_byte;
        logic              last_in_buffer;
    } t_byte_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CP_W-1:0]      i_cfg_data;

    utf8sd_byte_if byte_if ();
    utf8sd_cp_if   cp_if ();

    utf8_stream_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (byte_if),
        .o_cp        (cp_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the decoder: sequence state and the two registers.
    t_seq_state      seq        = '0;
    logic [CP_W-1:0] rep_cp_cfg = REP_CP_RESET;
    logic            rep_en_cfg = 1'b1;

    // Results still owed by the decoder, oldest first.
    t_result    pending_cp_q[$];
    // Bytes of the random buffer currently being sent.
    t_byte_item byte_q[$];

    t_stim_row   dir_tab [27];
    int          burst_left;
    int          mismatches = 0;
    int unsigned cycles_run = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    int unsigned stall_tick = 0;

    // Steps the shadow decoder by one byte. Returns 1 when the byte gives a
    // result, which is then left in r.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic eob,
                                       output t_result r);
        bit              emit;
        bit              rep;
        bit              bad;
        logic [CP_W-1:0] cp;
        emit = 1'b0;
        rep  = 1'b0;
        cp   = '0;
        r    = '0;
        if (!seq.halted) begin
            if (seq.left == 0) begin
                // A new sequence: the prefix bits give its length.
                seq.bad_lead    = 1'b0;
                seq.cont_broken = 1'b0;
                if (!b[7]) begin
                    seq.acc  = CP_W'(b);
                    seq.left = 3'd0;
                end else if (b[7:5] == 3'b110) begin
                    seq.acc  = CP_W'(b[4:0]);
                    seq.left = 3'd1;
                end else if (b[7:4] == 4'b1110) begin
                    seq.acc  = CP_W'(b[3:0]);
                    seq.left = 3'd2;
                end else if (b[7:3] == 5'b11110) begin
                    seq.acc  = CP_W'(b[2:0]);
                    seq.left = 3'd3;
                end else if (b[7:2] == 6'b111110) begin
                    seq.acc      = CP_W'(b[1:0]);
                    seq.left     = 3'd4;
                    seq.bad_lead = 1'b1;
                end else if (b[7:1] == 7'b1111110) begin
                    seq.acc      = CP_W'(b[0]);
                    seq.left     = 3'd5;
                    seq.bad_lead = 1'b1;
                end else begin
                    // A stray continuation byte or 0xFE/0xFF stands alone.
                    seq.acc      = CP_W'(b);
                    seq.left     = 3'd0;
                    seq.bad_lead = 1'b1;
                end
            end else begin
                // Once a continuation is bad, the remaining bytes only count down.
                if (!seq.cont_broken) begin
                    if (b[7:6] != 2'b10) begin
                        seq.cont_broken = 1'b1;
                    end else begin
                        seq.acc = {seq.acc[CP_W-7:0], b[5:0]};
                    end
                end
                seq.left = seq.left - 3'd1;
            end
            if (seq.left == 0) begin
                bad = seq.bad_lead || seq.acc == CP_NONCHAR_E || seq.acc == CP_NONCHAR_F
                      || seq.acc > CP_MAX;
                if (bad) begin
                    if (rep_en_cfg) begin
                        emit = 1'b1;
                        rep  = 1'b1;
                        cp   = rep_cp_cfg;
                    end
                end else begin
                    emit = 1'b1;
                    cp   = seq.acc;
                end
                seq.halted      = seq.cont_broken;
                seq.acc         = '0;
                seq.bad_lead    = 1'b0;
                seq.cont_broken = 1'b0;
            end
        end
        if (eob) begin
            r.code_point     = emit ? cp : '0;
            r.has_code_point = emit;
            r.replaced       = rep;
            r.end_of_buffer  = 1'b1;
            r.stopped_early  = seq.halted || seq.left != 0;
            seq              = '0;
            return 1'b1;
        end
        if (emit) begin
            r.code_point     = cp;
            r.has_code_point = 1'b1;
            r.replaced       = rep;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [BYTE_W-1:0] random_lead(input int len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            4:       return {5'b11110, 3'($urandom)};
            5:       return {6'b111110, 2'($urandom)};
            default: return {7'b1111110, 1'($urandom)};
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] random_cont();
        return {2'b10, 6'($urandom)};
    endfunction

    // Either a NUL or any byte that is not a continuation.
    function automatic logic [BYTE_W-1:0] broken_cont();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom);
        if (b[7:6] == 2'b10) begin
            b[6] = 1'b1;
        end
        return ($urandom_range(0, 1) == 0) ? 8'h00 : b;
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        t_byte_item it;
        it.data_byte      = b;
        it.last_in_buffer = 1'b0;
        byte_q = {byte_q, it};
    endfunction

    // Pushes the first keep bytes of a len-byte sequence; the continuation at
    // position bad_at (if non-zero) is corrupted.
    function automatic void add_sequence(input int len, input int keep, input int bad_at);
        push_byte(random_lead(len));
        for (int k = 1; k < keep; k++) begin
            push_byte((k == bad_at) ? broken_cont() : random_cont());
        end
    endfunction

    // One buffer of mostly well-formed text with random content, with some
    // invalid leads, broken sequences and noise mixed in. Now and then the
    // buffer ends part-way through a sequence.
    function automatic void make_buffer();
        int n_seq;
        int kind;
        int len;
        n_seq = $urandom_range(1, 8);
        for (int s = 0; s < n_seq; s++) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                push_byte({1'b0, 7'($urandom)});
            end else if (kind < 46) begin
                add_sequence(2, 2, 0);
            end else if (kind < 58) begin
                add_sequence(3, 3, 0);
            end else if (kind < 62) begin
                // The two non-characters at the end of the basic plane.
                push_byte(8'hEF);
                push_byte(8'hBF);
                push_byte({7'h5F, 1'($urandom)});
            end else if (kind < 72) begin
                add_sequence(4, 4, 0);
            end else if (kind < 76) begin
                // Either side of the top of the code space.
                push_byte(8'hF4);
                push_byte(($urandom_range(0, 1) == 0) ? 8'h8F : {4'b1001, 4'($urandom)});
                push_byte(($urandom_range(0, 1) == 0) ? 8'hBF : random_cont());
                push_byte(($urandom_range(0, 1) == 0) ? 8'hBF : random_cont());
            end else if (kind < 80) begin
                add_sequence(5, 5, 0);
            end else if (kind < 83) begin
                add_sequence(6, 6, 0);
            end else if (kind < 88) begin
                push_byte(($urandom_range(0, 4) == 0) ? {7'h7F, 1'($urandom)}
                                                       : random_cont());
            end else if (kind < 95) begin
                len = $urandom_range(2, 6);
                add_sequence(len, len, $urandom_range(1, len - 1));
            end else begin
                push_byte(8'($urandom));
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(2, 6);
            add_sequence(len, $urandom_range(1, len - 1), 0);
        end
        byte_q[byte_q.size() - 1].last_in_buffer = 1'b1;
    endfunction

    // Offers one byte, in bursts with random gaps, and books the result the
    // byte owes once its transaction has completed. Typed rows book the
    // hand-written result in place of the shadow decoder's.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob,
                             input bit typed, input t_result typed_res);
        int unsigned gap;
        t_result     r;
        bit          has;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        byte_if.valid          <= 1'b1;
        byte_if.data_byte      <= b;
        byte_if.last_in_buffer <= eob;
        do begin
            @(posedge i_clk);
        end while (!(byte_if.valid === 1'b1 && byte_if.ready === 1'b1));
        has = decode_byte(b, eob, r);
        if (typed) begin
            pending_cp_q = {pending_cp_q, typed_res};
        end else if (has) begin
            pending_cp_q = {pending_cp_q, r};
        end
    endtask

    // Holds the sender off until every owed result has come out, then lets
    // the pipeline settle.
    task automatic drain_results();
        byte_if.valid <= 1'b0;
        while (pending_cp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // The write enable is left high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CP_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_REP_CP) begin
            rep_cp_cfg = val;
        end else begin
            rep_en_cfg = val[0];
        end
    endtask

    // Receiver: the ready pattern is redrawn each time its countdown runs out,
    // choosing between always ready, mostly ready, a fixed one-in-three stall
    // and mostly stalled. Every result transaction is checked here against the
    // oldest booked result.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0:       cp_if.ready <= 1'b1;
            1:       cp_if.ready <= ($urandom_range(0, 9) < 7);
            2:       cp_if.ready <= (stall_tick % 3 != 0);
            default: cp_if.ready <= ($urandom_range(0, 9) < 3);
        endcase

        if (i_rst_n === 1'b1 && cp_if.valid === 1'b1 && cp_if.ready === 1'b1) begin
            got = {cp_if.code_point, cp_if.has_code_point, cp_if.replaced,
                   cp_if.end_of_buffer, cp_if.stopped_early};
            if (pending_cp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: cp=%06h has=%0b rep=%0b eob=%0b stop=%0b",
                             got.code_point, got.has_code_point, got.replaced,
                             got.end_of_buffer, got.stopped_early);
                end
            end else begin
                want = pending_cp_q.pop_front();
                if (got.code_point !== want.code_point
                        || got.has_code_point !== want.has_code_point
                        || got.replaced !== want.replaced
                        || got.end_of_buffer !== want.end_of_buffer
                        || got.stopped_early !== want.stopped_early) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: want cp=%06h has=%0b rep=%0b eob=%0b stop=%0b",
                                 want.code_point, want.has_code_point, want.replaced,
                                 want.end_of_buffer, want.stopped_early);
                        $display("          got  cp=%06h has=%0b rep=%0b eob=%0b stop=%0b",
                                 got.code_point, got.has_code_point, got.replaced,
                                 got.end_of_buffer, got.stopped_early);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == RUN_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [CP_W-1:0] cp_val;
        logic            en_val;
        int              sent;
        t_byte_item      it;

        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = CFG_REP_CP;
        i_cfg_data             = '0;
        byte_if.valid          = 1'b0;
        byte_if.data_byte      = '0;
        byte_if.last_in_buffer = 1'b0;
        burst_left             = 0;

        // Directed part, run with the registers at their reset values. Rows
        // that close a sequence with an obvious outcome carry it typed in.
        dir_tab = '{
            // NUL straight after reset, then 0xFF as a lead on its own.
            '{8'h00, 1'b0, 1'b1, RES_NUL},
            '{8'hFF, 1'b0, 1'b1, RES_REP},
            // U+FFFE is replaced.
            '{8'hEF, 1'b0, 1'b0, NO_RES},
            '{8'hBF, 1'b0, 1'b0, NO_RES},
            '{8'hBE, 1'b0, 1'b1, RES_REP},
            // U+FFFF is replaced, and its last byte also closes the buffer.
            '{8'hEF, 1'b0, 1'b0, NO_RES},
            '{8'hBF, 1'b0, 1'b0, NO_RES},
            '{8'hBF, 1'b1, 1'b1, RES_REP_END},
            // One past the top of the code space.
            '{8'hF4, 1'b0, 1'b0, NO_RES},
            '{8'h90, 1'b0, 1'b0, NO_RES},
            '{8'h80, 1'b0, 1'b0, NO_RES},
            '{8'h80, 1'b0, 1'b1, RES_REP},
            // Five-byte form: every byte is taken before the replacement.
            '{8'hF8, 1'b0, 1'b0, NO_RES},
            '{8'h88, 1'b0, 1'b0, NO_RES},
            '{8'h80, 1'b0, 1'b0, NO_RES},
            '{8'h80, 1'b0, 1'b0, NO_RES},
            '{8'h80, 1'b0, 1'b1, RES_REP},
            // Six-byte form.
            '{8'hFC, 1'b0, 1'b0, NO_RES},
            '{8'h84, 1'b0, 1'b0, NO_RES},
            '{8'h80, 1'b0, 1'b0, NO_RES},
            '{8'h80, 1'b0, 1'b0, NO_RES},
            '{8'h80, 1'b0, 1'b0, NO_RES},
            '{8'h80, 1'b0, 1'b1, RES_REP},
            // NUL as a continuation: the partial value still comes out, then
            // decoding halts and the rest of the buffer is ignored.
            '{8'hC3, 1'b0, 1'b0, NO_RES},
            '{8'h00, 1'b0, 1'b0, NO_RES},
            '{8'h41, 1'b1, 1'b1, RES_CUT_END},
            // A buffer that ends on a bare lead byte.
            '{8'hC3, 1'b1, 1'b1, RES_CUT_END}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].data_byte, dir_tab[i].last_in_buffer,
                      dir_tab[i].typed, dir_tab[i].want);
        end

        // Random part, in phases. Each phase starts from an empty pipeline
        // with a fresh register setting; a buffer may straddle two phases.
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       begin cp_val = '0;                          en_val = 1'b1; end
                1:       begin cp_val = CP_MAX;                      en_val = 1'b1; end
                2:       begin cp_val = CP_W'($urandom_range(0, CP_MAX)); en_val = 1'b0; end
                3:       begin cp_val = CP_W'($urandom_range(0, CP_MAX)); en_val = 1'b1; end
                4:       begin cp_val = REP_CP_RESET;                en_val = 1'b0; end
                default: begin cp_val = CP_W'($urandom_range(0, CP_MAX)); en_val = 1'b1; end
            endcase
            drain_results();
            write_reg(CFG_REP_CP, cp_val);
            write_reg(CFG_REP_EN, CP_W'(en_val));
            i_cfg_we <= 1'b0;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (byte_q.size() == 0) begin
                    make_buffer();
                end
                it = byte_q.pop_front();
                send_byte(it.data_byte, it.last_in_buffer, 1'b0, NO_RES);
                sent++;
            end
        end

        drain_results();
        if (mismatches == 0 && pending_cp_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
